>>> rtl/rbfp_pkg.sv
// Shared types, codes and constants of the rectangle blit frame parser.
package rbfp_pkg;

  localparam int COORD_BITS   = 12;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_IDX_BITS = $clog2(HEADER_BYTES);

  localparam logic [31:0] MIN_FRAME_BYTES = 32'd16;

  localparam logic [11:0] RST_SCREEN_WIDTH     = 12'd320;
  localparam logic [11:0] RST_SCREEN_HEIGHT    = 12'd240;
  localparam logic [20:0] RST_MAX_FRAME_BYTES  = 21'd524288;
  localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd1;
  localparam logic [7:0]  RST_EXPECTED_KIND    = 8'd1;

  typedef enum logic [1:0] {
    EV_PIXEL = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_BAD_LENGTH      = 3'd1,
    ST_BAD_HEADER      = 3'd2,
    ST_BAD_RECT        = 3'd3,
    ST_LENGTH_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH     = 3'd0,
    REG_SCREEN_HEIGHT    = 3'd1,
    REG_MAX_FRAME_BYTES  = 3'd2,
    REG_EXPECTED_VERSION = 3'd3,
    REG_EXPECTED_KIND    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [20:0] max_frame_bytes;
    logic [7:0]  expected_version;
    logic [7:0]  expected_kind;
  } cfg_t;

  typedef struct packed {
    logic                  has_result;
    event_kind_t           kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [15:0]           color;
    status_t               status;
  } result_t;

endpackage

>>> rtl/rbfp_cfg_regs.sv
// Configuration register file of the rectangle blit frame parser.
module rbfp_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [20:0]         cfg_data,
  output rbfp_pkg::cfg_t      cfg
);
  import rbfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width     <= RST_SCREEN_WIDTH;
      cfg.screen_height    <= RST_SCREEN_HEIGHT;
      cfg.max_frame_bytes  <= RST_MAX_FRAME_BYTES;
      cfg.expected_version <= RST_EXPECTED_VERSION;
      cfg.expected_kind    <= RST_EXPECTED_KIND;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_SCREEN_WIDTH:     cfg.screen_width     <= cfg_data[11:0];
        REG_SCREEN_HEIGHT:    cfg.screen_height    <= cfg_data[11:0];
        REG_MAX_FRAME_BYTES:  cfg.max_frame_bytes  <= cfg_data;
        REG_EXPECTED_VERSION: cfg.expected_version <= cfg_data[7:0];
        REG_EXPECTED_KIND:    cfg.expected_kind    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rbfp_parse_core.sv
// Frame parsing state and the combinational step logic for one stream byte.
module rbfp_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  rbfp_pkg::cfg_t    cfg,
  output rbfp_pkg::result_t res
);
  import rbfp_pkg::*;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_HEADER = 2'd1,
    PH_PIXELS = 2'd2
  } phase_t;

  localparam logic [HDR_IDX_BITS-1:0] IDX_VERSION = HDR_IDX_BITS'(0);
  localparam logic [HDR_IDX_BITS-1:0] IDX_KIND    = HDR_IDX_BITS'(1);
  localparam logic [HDR_IDX_BITS-1:0] IDX_X_HI    = HDR_IDX_BITS'(8);
  localparam logic [HDR_IDX_BITS-1:0] IDX_X_LO    = HDR_IDX_BITS'(9);
  localparam logic [HDR_IDX_BITS-1:0] IDX_Y_HI    = HDR_IDX_BITS'(10);
  localparam logic [HDR_IDX_BITS-1:0] IDX_Y_LO    = HDR_IDX_BITS'(11);
  localparam logic [HDR_IDX_BITS-1:0] IDX_W_HI    = HDR_IDX_BITS'(12);
  localparam logic [HDR_IDX_BITS-1:0] IDX_W_LO    = HDR_IDX_BITS'(13);
  localparam logic [HDR_IDX_BITS-1:0] IDX_H_HI    = HDR_IDX_BITS'(14);
  localparam logic [HDR_IDX_BITS-1:0] IDX_H_LO    = HDR_IDX_BITS'(15);
  localparam logic [HDR_IDX_BITS-1:0] IDX_LEN_END = HDR_IDX_BITS'(3);

  phase_t                  phase, phase_next;
  logic [HDR_IDX_BITS-1:0] byte_index, byte_index_next;
  logic [31:0]             frame_length, frame_length_next;
  logic [15:0]             rect_x, rect_x_next, rect_y, rect_y_next;
  logic [15:0]             rect_w, rect_w_next, rect_h, rect_h_next;
  logic [11:0]             column_count, column_count_next;
  logic [11:0]             row_count, row_count_next;
  logic [7:0]              high_byte_hold, high_byte_hold_next;
  logic                    error_latched, error_latched_next;
  logic                    header_bad, header_bad_next;
  logic [23:0]             area_hi, area_hi_next;
  logic                    length_exact, length_exact_next;

  // The area w*h is built from two 16x8 products: the high byte of h at
  // header byte 14, the low byte at header byte 15.
  logic [23:0] w_by_byte;
  logic [31:0] area;
  logic [33:0] need_bytes;
  logic [31:0] length_shift;
  logic [15:0] h_full;
  logic [12:0] col_inc, row_inc;

  assign w_by_byte    = {8'd0, rect_w} * {16'd0, data_byte};
  assign area         = {area_hi, 8'd0} + {8'd0, w_by_byte};
  assign need_bytes   = {2'd0, MIN_FRAME_BYTES} + {1'b0, area, 1'b0};
  assign length_shift = {frame_length[23:0], data_byte};
  assign h_full       = {rect_h[7:0], data_byte};
  assign col_inc      = {1'b0, column_count} + 13'd1;
  assign row_inc      = {1'b0, row_count} + 13'd1;

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    frame_length_next   = frame_length;
    rect_x_next         = rect_x;
    rect_y_next         = rect_y;
    rect_w_next         = rect_w;
    rect_h_next         = rect_h;
    column_count_next   = column_count;
    row_count_next      = row_count;
    high_byte_hold_next = high_byte_hold;
    error_latched_next  = error_latched;
    header_bad_next     = header_bad;
    area_hi_next        = area_hi;
    length_exact_next   = length_exact;
    res                 = '0;
    res.kind            = EV_PIXEL;
    res.status          = ST_OK;

    if (!error_latched) begin
      case (phase)
        PH_LENGTH: begin
          frame_length_next = length_shift;
          if (byte_index == IDX_LEN_END) begin
            byte_index_next = '0;
            if (length_shift < MIN_FRAME_BYTES ||
                length_shift > {11'd0, cfg.max_frame_bytes}) begin
              error_latched_next = 1'b1;
              res.has_result     = 1'b1;
              res.kind           = EV_ERROR;
              res.status         = ST_BAD_LENGTH;
            end else begin
              phase_next      = PH_HEADER;
              header_bad_next = 1'b0;
              rect_x_next     = '0;
              rect_y_next     = '0;
              rect_w_next     = '0;
              rect_h_next     = '0;
            end
          end else begin
            byte_index_next = byte_index + 1'b1;
          end
        end

        PH_HEADER: begin
          if (byte_index == IDX_VERSION && data_byte != cfg.expected_version) begin
            header_bad_next = 1'b1;
          end
          if (byte_index == IDX_KIND && data_byte != cfg.expected_kind) begin
            header_bad_next = 1'b1;
          end
          if (byte_index == IDX_X_HI || byte_index == IDX_X_LO) begin
            rect_x_next = {rect_x[7:0], data_byte};
          end
          if (byte_index == IDX_Y_HI || byte_index == IDX_Y_LO) begin
            rect_y_next = {rect_y[7:0], data_byte};
          end
          if (byte_index == IDX_W_HI || byte_index == IDX_W_LO) begin
            rect_w_next = {rect_w[7:0], data_byte};
          end
          if (byte_index == IDX_H_HI || byte_index == IDX_H_LO) begin
            rect_h_next = h_full;
          end
          if (byte_index == IDX_H_HI) begin
            area_hi_next = w_by_byte;
          end
          byte_index_next = byte_index + 1'b1;
          if (byte_index == IDX_H_LO) begin
            byte_index_next = '0;
            if (header_bad) begin
              error_latched_next = 1'b1;
              res.has_result     = 1'b1;
              res.kind           = EV_ERROR;
              res.status         = ST_BAD_HEADER;
            end else if (rect_w == 16'd0 || h_full == 16'd0 ||
                         ({1'b0, rect_x} + {1'b0, rect_w}) >
                           {5'd0, cfg.screen_width} ||
                         ({1'b0, rect_y} + {1'b0, h_full}) >
                           {5'd0, cfg.screen_height} ||
                         {2'd0, frame_length} < need_bytes) begin
              error_latched_next = 1'b1;
              res.has_result     = 1'b1;
              res.kind           = EV_ERROR;
              res.status         = ST_BAD_RECT;
            end else begin
              phase_next        = PH_PIXELS;
              column_count_next = '0;
              row_count_next    = '0;
              length_exact_next = ({2'd0, frame_length} == need_bytes);
            end
          end
        end

        PH_PIXELS: begin
          if (byte_index == '0) begin
            high_byte_hold_next = data_byte;
            byte_index_next     = HDR_IDX_BITS'(1);
          end else begin
            byte_index_next   = '0;
            res.has_result    = 1'b1;
            res.x             = rect_x[COORD_BITS-1:0] + column_count;
            res.y             = rect_y[COORD_BITS-1:0] + row_count;
            res.color         = {high_byte_hold, data_byte};
            column_count_next = col_inc[11:0];
            if ({3'd0, col_inc} >= rect_w) begin
              column_count_next = '0;
              row_count_next    = row_inc[11:0];
              if ({3'd0, row_inc} >= rect_h) begin
                row_count_next = '0;
                if (!length_exact) begin
                  // Surplus bytes after the rectangle: report and stop.
                  error_latched_next = 1'b1;
                  res.kind           = EV_ERROR;
                  res.status         = ST_LENGTH_MISMATCH;
                end else begin
                  phase_next        = PH_LENGTH;
                  frame_length_next = '0;
                  res.kind          = EV_DONE;
                end
              end
            end
          end
        end

        default: begin
          phase_next = PH_LENGTH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LENGTH;
      byte_index     <= '0;
      frame_length   <= '0;
      rect_x         <= '0;
      rect_y         <= '0;
      rect_w         <= '0;
      rect_h         <= '0;
      column_count   <= '0;
      row_count      <= '0;
      high_byte_hold <= '0;
      error_latched  <= 1'b0;
      header_bad     <= 1'b0;
      area_hi        <= '0;
      length_exact   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      frame_length   <= frame_length_next;
      rect_x         <= rect_x_next;
      rect_y         <= rect_y_next;
      rect_w         <= rect_w_next;
      rect_h         <= rect_h_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      high_byte_hold <= high_byte_hold_next;
      error_latched  <= error_latched_next;
      header_bad     <= header_bad_next;
      area_hi        <= area_hi_next;
      length_exact   <= length_exact_next;
    end
  end

endmodule

>>> rtl/rect_blit_frame_parser.sv
// Top level of the rectangle blit frame parser: input and result registers.
//
// Bytes of framed rectangle updates arrive on the byte channel (byte_valid,
// byte_ready, data_byte), one byte per transfer. A frame is a big-endian
// length word, a sixteen-byte header and the RGB565 pixels of the rectangle.
// Every pixel gives one transfer on the event channel (event_valid,
// event_ready) with its screen coordinates and color; the last pixel of a
// frame is reported as frame done or as a length mismatch. A length, header
// or rectangle error gives one error event, after which every further byte
// is swallowed until reset. The configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) writes the screen size, the largest frame length and
// the expected version and kind bytes; cfg_ready is always high.
// Throughput is one byte per cycle. The event a byte causes passes through the
// input register and the result register before it is offered. When the
// receiver stalls, the result register holds its event
// and bytes that produce no event keep flowing; the byte channel stalls only
// when a new event would have nowhere to go. Synchronous reset restores the
// default configuration, empties both registers and makes the parser expect
// a length word.
module rect_blit_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [7:0]                    data_byte,
  output logic                          event_valid,
  input  logic                          event_ready,
  output logic [1:0]                    event_kind,
  output logic [rbfp_pkg::COORD_BITS-1:0] pixel_x,
  output logic [rbfp_pkg::COORD_BITS-1:0] pixel_y,
  output logic [15:0]                   pixel_color,
  output logic [2:0]                    status_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [20:0]                   cfg_data
);
  import rbfp_pkg::*;

  cfg_t    cfg;
  result_t res;

  // Input register: holds one accepted byte until the parser steps on it.
  logic       byte_held;
  logic [7:0] byte_q;
  logic       advance;

  // The held byte moves on when its event, if any, has room in the
  // result register.
  assign advance    = byte_held && (!res.has_result || !event_valid || event_ready);
  assign byte_ready = !byte_held || advance;
  assign cfg_ready  = 1'b1;

  rbfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rbfp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (byte_q),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_held <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      byte_held <= 1'b1;
    end else if (advance) begin
      byte_held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      byte_q <= data_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance && res.has_result) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.has_result) begin
      event_kind  <= res.kind;
      pixel_x     <= res.x;
      pixel_y     <= res.y;
      pixel_color <= res.color;
      status_code <= res.status;
    end
  end

  // Once an error event has been produced, the parser produces nothing more.
  assert property (@(posedge clk) disable iff (rst)
    (advance && res.has_result && res.kind == EV_ERROR) |=> !res.has_result)
    else $error("parser produced an event after a latched error");

  // Pixel and frame done events always carry the ok status.
  assert property (@(posedge clk) disable iff (rst)
    (event_valid && (event_kind == EV_PIXEL || event_kind == EV_DONE))
      |-> (status_code == ST_OK))
    else $error("non-error event with a failure status");

  // A held byte that cannot step stays in the input register unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (byte_held && !advance) |=> (byte_held && $stable(byte_q)))
    else $error("input register lost a byte that had not been parsed");

  // Reset empties the result register.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !event_valid)
    else $error("event offered right after reset");

endmodule

>>> bench/rbfp_event_checker.sv
// Event checker for the rectangle blit frame parser: predicts and compares every event.
module rbfp_event_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  input  logic                            byte_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            event_valid,
  input  logic                            event_ready,
  input  logic [1:0]                      event_kind,
  input  logic [rbfp_pkg::COORD_BITS-1:0] pixel_x,
  input  logic [rbfp_pkg::COORD_BITS-1:0] pixel_y,
  input  logic [15:0]                     pixel_color,
  input  logic [2:0]                      status_code,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [20:0]                     cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              events_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbfp_pkg::*;

  typedef struct packed {
    event_kind_t           kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [15:0]           color;
    status_t               status;
  } blit_event_t;

  typedef enum logic [1:0] {
    SEEK_LENGTH,
    IN_HEADER,
    IN_PIXELS
  } parse_phase_t;

  // Shadow copy of the parser state and its registers.
  cfg_t         cfg;
  parse_phase_t phase;
  logic [4:0]   byte_idx;
  logic [31:0]  frame_len;
  logic [15:0]  rect_x, rect_y, rect_w, rect_h;
  logic [11:0]  col_cnt, row_cnt;
  logic [7:0]   high_hold;
  logic         latched, hdr_bad;

  blit_event_t  expected_events[$];

  function automatic blit_event_t error_event(status_t code);
    blit_event_t e;
    e = '0;
    e.kind = EV_ERROR;
    e.status = code;
    return e;
  endfunction

  function automatic logic [63:0] bytes_needed();
    return 64'(MIN_FRAME_BYTES) + {48'd0, rect_w} * {48'd0, rect_h} * 64'd2;
  endfunction

  task automatic parse_byte(input logic [7:0] b, output logic produced,
                            output blit_event_t ev);
    logic [16:0] x_end, y_end;
    produced = 1'b0;
    ev = '0;
    ev.kind = EV_PIXEL;
    ev.status = ST_OK;
    if (!latched) begin
      case (phase)
        SEEK_LENGTH: begin
          frame_len = {frame_len[23:0], b};
          byte_idx = byte_idx + 5'd1;
          if (byte_idx == 5'd4) begin
            byte_idx = '0;
            if (frame_len < MIN_FRAME_BYTES || frame_len > {11'd0, cfg.max_frame_bytes}) begin
              produced = 1'b1;
              ev = error_event(ST_BAD_LENGTH);
              latched = 1'b1;
            end else begin
              phase = IN_HEADER;
              hdr_bad = 1'b0;
              rect_x = '0;
              rect_y = '0;
              rect_w = '0;
              rect_h = '0;
            end
          end
        end
        IN_HEADER: begin
          if (byte_idx == 5'd0 && b != cfg.expected_version) hdr_bad = 1'b1;
          if (byte_idx == 5'd1 && b != cfg.expected_kind) hdr_bad = 1'b1;
          case (byte_idx)
            5'd8, 5'd9:   rect_x = {rect_x[7:0], b};
            5'd10, 5'd11: rect_y = {rect_y[7:0], b};
            5'd12, 5'd13: rect_w = {rect_w[7:0], b};
            5'd14, 5'd15: rect_h = {rect_h[7:0], b};
            default: ;
          endcase
          byte_idx = byte_idx + 5'd1;
          if (byte_idx == HEADER_BYTES) begin
            byte_idx = '0;
            x_end = {1'b0, rect_x} + {1'b0, rect_w};
            y_end = {1'b0, rect_y} + {1'b0, rect_h};
            if (hdr_bad) begin
              produced = 1'b1;
              ev = error_event(ST_BAD_HEADER);
              latched = 1'b1;
            end else if (rect_w == '0 || rect_h == '0 ||
                         x_end > {5'd0, cfg.screen_width} ||
                         y_end > {5'd0, cfg.screen_height} ||
                         {32'd0, frame_len} < bytes_needed()) begin
              produced = 1'b1;
              ev = error_event(ST_BAD_RECT);
              latched = 1'b1;
            end else begin
              phase = IN_PIXELS;
              col_cnt = '0;
              row_cnt = '0;
            end
          end
        end
        default: begin
          if (byte_idx == 5'd0) begin
            high_hold = b;
            byte_idx = 5'd1;
          end else begin
            byte_idx = '0;
            produced = 1'b1;
            ev.color = {high_hold, b};
            ev.x = rect_x[COORD_BITS-1:0] + col_cnt;
            ev.y = rect_y[COORD_BITS-1:0] + row_cnt;
            col_cnt = col_cnt + 12'd1;
            if ({4'd0, col_cnt} >= rect_w) begin
              col_cnt = '0;
              row_cnt = row_cnt + 12'd1;
              if ({4'd0, row_cnt} >= rect_h) begin
                row_cnt = '0;
                if ({32'd0, frame_len} != bytes_needed()) begin
                  ev.kind = EV_ERROR;
                  ev.status = ST_LENGTH_MISMATCH;
                  latched = 1'b1;
                end else begin
                  ev.kind = EV_DONE;
                  phase = SEEK_LENGTH;
                  frame_len = '0;
                end
              end
            end
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: event %0d %s mismatch, expected %0h, actual %0h",
               $time, events_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    blit_event_t got, want, predicted;
    logic        produced;
    if (rst) begin
      cfg.screen_width     = RST_SCREEN_WIDTH;
      cfg.screen_height    = RST_SCREEN_HEIGHT;
      cfg.max_frame_bytes  = RST_MAX_FRAME_BYTES;
      cfg.expected_version = RST_EXPECTED_VERSION;
      cfg.expected_kind    = RST_EXPECTED_KIND;
      phase = SEEK_LENGTH;
      byte_idx = '0;
      frame_len = '0;
      rect_x = '0;
      rect_y = '0;
      rect_w = '0;
      rect_h = '0;
      col_cnt = '0;
      row_cnt = '0;
      high_hold = '0;
      latched = 1'b0;
      hdr_bad = 1'b0;
      mismatches = 0;
      events_checked = 0;
      expected_events.delete();
    end else begin
      if (event_valid && event_ready) begin
        got.kind   = event_kind_t'(event_kind);
        got.x      = pixel_x;
        got.y      = pixel_y;
        got.color  = pixel_color;
        got.status = status_t'(status_code);
        if (expected_events.size() == 0) begin
          mismatches++;
          $display("%0t: event with none expected, expected nothing, actual kind %0d",
                   $time, event_kind);
          $display("  x %0d y %0d color %0h status %0d",
                   pixel_x, pixel_y, pixel_color, status_code);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 16'(want.kind), 16'(got.kind));
          check_field("pixel_x", 16'(want.x), 16'(got.x));
          check_field("pixel_y", 16'(want.y), 16'(got.y));
          check_field("pixel_color", want.color, got.color);
          check_field("status_code", 16'(want.status), 16'(got.status));
          events_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:     cfg.screen_width     = cfg_data[11:0];
          REG_SCREEN_HEIGHT:    cfg.screen_height    = cfg_data[11:0];
          REG_MAX_FRAME_BYTES:  cfg.max_frame_bytes  = cfg_data;
          REG_EXPECTED_VERSION: cfg.expected_version = cfg_data[7:0];
          REG_EXPECTED_KIND:    cfg.expected_kind    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (byte_valid && byte_ready) begin
        parse_byte(data_byte, produced, predicted);
        if (produced) expected_events.push_back(predicted);
      end
    end
    outstanding <= expected_events.size();
  end

endmodule

>>> bench/tb_rect_blit_frame_parser.sv
// Top of the rectangle blit frame parser testbench: stimulus, watchdog and verdict.
module tb_rect_blit_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import rbfp_pkg::*;

  // Percentage of cycles in which the sender holds back a byte or the
  // receiver holds back an event.
  localparam int IDLE_PERCENT   = 29;
  // Window of byte counts in which neither side idles at all.
  localparam int STEADY_FIRST   = 500;
  localparam int STEADY_LAST    = 800;
  // The random part keeps adding register settings until this many bytes
  // have gone through.
  localparam int RANDOM_BYTES   = 1500;
  // The parser offers an event after the input and result registers; this
  // pause covers that with margin before a register write or the verdict.
  localparam int DRAIN_CYCLES   = 8;
  localparam int NOISE_BYTES    = 24;
  localparam int WATCHDOG_LIMIT = 5000;

  // The closing frame of the run breaks one of the parser's checks. Since
  // an error latches until reset and reset comes only once, a run can end
  // in one error only; the seed picks which.
  typedef enum int {
    FAULT_LENGTH,
    FAULT_HEADER,
    FAULT_RECT,
    FAULT_MISMATCH
  } fault_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  byte_valid  = 1'b0;
  logic                  byte_ready;
  logic [7:0]            data_byte   = '0;
  logic                  event_valid;
  logic                  event_ready = 1'b0;
  logic [1:0]            event_kind;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [15:0]           pixel_color;
  logic [2:0]            status_code;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index   = '0;
  logic [20:0]           cfg_data    = '0;

  int mismatches;
  int outstanding;
  int events_checked;

  // Stimulus bookkeeping. The current register values are tracked here so
  // that well-formed frames can be built against them.
  logic steady = 1'b0;
  int   bytes_sent = 0;
  int   frames_sent = 0;
  int   settings_used = 1;
  int   quiet_cycles = 0;
  int   cur_sw = RST_SCREEN_WIDTH;
  int   cur_sh = RST_SCREEN_HEIGHT;
  int   cur_mfb = RST_MAX_FRAME_BYTES;
  int   cur_ver = RST_EXPECTED_VERSION;
  int   cur_kind = RST_EXPECTED_KIND;

  always #5 clk = ~clk;

  rect_blit_frame_parser dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .data_byte   (data_byte),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .status_code (status_code),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  rbfp_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .data_byte      (data_byte),
    .event_valid    (event_valid),
    .event_ready    (event_ready),
    .event_kind     (event_kind),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_color    (pixel_color),
    .status_code    (status_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .events_checked (events_checked)
  );

  // The receiver stalls at random, except inside the steady window.
  always @(posedge clk) begin
    event_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // The watchdog counts cycles in which no transfer happens on any channel.
  // A parser that stops delivering events, or never empties the list of
  // expected events, ends up here.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (event_valid && event_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d events still expected",
               WATCHDOG_LIMIT, outstanding);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A negative fill asks for random bytes; anything else is repeated.
  function automatic logic [7:0] fill_byte(input int fill);
    logic [7:0] r;
    r = $urandom_range(255);
    return (fill < 0) ? r : fill[7:0];
  endfunction

  // Sizes for random register settings: now and then a tiny screen, so that
  // rectangles often touch the edges, otherwise anything up to the maximum.
  function automatic int random_dim();
    return ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(17, 4095);
  endfunction

  // One byte transfer. The gap before it is taken with valid low; once valid
  // is raised it stays up with the same byte until the transfer. The caller
  // leaves valid high when the next byte follows at once, so valid is never
  // lowered and raised in the same time step.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
    steady <= (bytes_sent >= STEADY_FIRST) && (bytes_sent < STEADY_LAST);
  endtask

  // The length word goes most significant byte first.
  task automatic send_word(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  // Header bytes two through seven are don't-care filler.
  task automatic send_header(input logic [7:0] ver, input logic [7:0] kind,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] w, input logic [15:0] h,
                             input int fill);
    send_byte(ver);
    send_byte(kind);
    repeat (6) send_byte(fill_byte(fill));
    send_byte(x[15:8]);
    send_byte(x[7:0]);
    send_byte(y[15:8]);
    send_byte(y[7:0]);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
    send_byte(h[15:8]);
    send_byte(h[7:0]);
  endtask

  task automatic send_pixels(input int count, input int fill);
    repeat (count) send_byte(fill_byte(fill));
  endtask

  // A well-formed frame against the current registers: exact length,
  // matching version and kind, and a rectangle inside the screen.
  task automatic send_frame(input int x, input int y, input int w, input int h,
                            input int fill);
    send_word(16 + 2 * w * h);
    send_header(cur_ver[7:0], cur_kind[7:0], 16'(x), 16'(y), 16'(w), 16'(h), fill);
    send_pixels(2 * w * h, fill);
    frames_sent++;
  endtask

  // Random well-formed frames. Most rectangles are a few pixels; some are a
  // single long row. About one in four hugs the right edge, one in four the bottom.
  task automatic random_frame();
    int w, h, x, y;
    if ($urandom_range(7) == 0) begin
      w = $urandom_range(1, (cur_sw < 48) ? cur_sw : 48);
      h = 1;
    end else begin
      w = $urandom_range(1, (cur_sw < 6) ? cur_sw : 6);
      h = $urandom_range(1, (cur_sh < 4) ? cur_sh : 4);
    end
    x = ($urandom_range(3) == 0) ? cur_sw - w : $urandom_range(0, cur_sw - w);
    y = ($urandom_range(3) == 0) ? cur_sh - h : $urandom_range(0, cur_sh - h);
    send_frame(x, y, w, h, -1);
  endtask

  // Bring the parser to rest: drop valid, wait until every expected event
  // has been delivered, then give the pipeline time to run dry. The first
  // edge lets the checker count the last byte's event.
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A register write keeps cfg_valid high; the caller lowers it after the
  // last write of a burst.
  task automatic write_reg(input reg_index_t idx, input logic [20:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all five registers. Only called with the parser at rest.
  task automatic configure(input int sw, input int sh, input int mfb,
                           input int ver, input int kind);
    write_reg(REG_SCREEN_WIDTH, sw[20:0]);
    write_reg(REG_SCREEN_HEIGHT, sh[20:0]);
    write_reg(REG_MAX_FRAME_BYTES, mfb[20:0]);
    write_reg(REG_EXPECTED_VERSION, ver[20:0]);
    write_reg(REG_EXPECTED_KIND, kind[20:0]);
    cfg_valid <= 1'b0;
    cur_sw = sw;
    cur_sh = sh;
    cur_mfb = mfb;
    cur_ver = ver;
    cur_kind = kind;
    settings_used++;
  endtask

  // The closing frame breaks one check in one of several ways, then noise
  // follows that the latched parser must swallow without a single event.
  task automatic send_fault(input fault_t fault);
    int w, h, x, y, variant;
    logic [31:0] need;
    logic [7:0] bad_ver, bad_kind;
    w = $urandom_range(1, (cur_sw < 4) ? cur_sw : 4);
    h = $urandom_range(1, (cur_sh < 4) ? cur_sh : 4);
    x = $urandom_range(0, cur_sw - w);
    y = $urandom_range(0, cur_sh - h);
    need = 16 + 2 * w * h;
    variant = $urandom_range(0, 4);
    case (fault)
      FAULT_LENGTH: begin
        if (variant == 0) begin
          // A length limit of the minimum frame length: no frame with pixels can pass it.
          configure(cur_sw, cur_sh, MIN_FRAME_BYTES, cur_ver, cur_kind);
          send_word(need);
        end else if (variant <= 2) begin
          send_word($urandom_range(0, 15));
        end else if (variant == 3) begin
          send_word(cur_mfb + $urandom_range(1, 4096));
        end else begin
          send_word(32'hffff_ffff);
        end
      end
      FAULT_HEADER: begin
        // A wrong version, a wrong kind, or both.
        bad_ver = cur_ver[7:0];
        bad_kind = cur_kind[7:0];
        if (variant != 1) bad_ver = bad_ver ^ 8'($urandom_range(1, 255));
        if (variant != 0) bad_kind = bad_kind ^ 8'($urandom_range(1, 255));
        send_word(need);
        send_header(bad_ver, bad_kind, 16'(x), 16'(y), 16'(w), 16'(h), -1);
      end
      FAULT_RECT: begin
        case (variant)
          0: begin
            send_word(16 + 2 * $urandom_range(0, 4));
            send_header(cur_ver[7:0], cur_kind[7:0], 16'(x), 16'(y), 16'd0, 16'(h), -1);
          end
          1: begin
            send_word(16 + 2 * $urandom_range(0, 4));
            send_header(cur_ver[7:0], cur_kind[7:0], 16'(x), 16'(y), 16'(w), 16'd0, -1);
          end
          2: begin
            send_word(need);
            send_header(cur_ver[7:0], cur_kind[7:0],
                        16'($urandom_range(cur_sw - w + 1, 65535)),
                        16'(y), 16'(w), 16'(h), -1);
          end
          3: begin
            send_word(need);
            send_header(cur_ver[7:0], cur_kind[7:0], 16'(x),
                        16'($urandom_range(cur_sh - h + 1, 65535)),
                        16'(w), 16'(h), -1);
          end
          default: begin
            // A length too short for the rectangle it announces.
            send_word(need - $urandom_range(1, need - 16));
            send_header(cur_ver[7:0], cur_kind[7:0], 16'(x), 16'(y), 16'(w), 16'(h), -1);
          end
        endcase
      end
      default: begin
        // A length longer than the pixels: reported on the last pixel.
        send_word(need + $urandom_range(1, 16));
        send_header(cur_ver[7:0], cur_kind[7:0], 16'(x), 16'(y), 16'(w), 16'(h), -1);
        send_pixels(2 * w * h, -1);
      end
    endcase
    send_pixels(NOISE_BYTES, -1);
  endtask

  initial begin : stimulus
    fault_t fault;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. A single pixel in the bottom right corner, all ones.
    send_frame(319, 239, 1, 1, 255);
    repeat (8) random_frame();

    // Largest screen and a length limit of 1048576, version zero and kind all ones,
    // with a pixel at the largest coordinates, all zeros.
    settle();
    configure(4095, 4095, 1048576, 0, 255);
    send_frame(4094, 4094, 1, 1, 0);
    repeat (10) random_frame();

    // A one-pixel screen whose length limit fits exactly one pixel.
    settle();
    configure(1, 1, 18, 255, 0);
    repeat (10) random_frame();

    // Random register settings, each carrying a handful of frames.
    do begin
      settle();
      configure(random_dim(), random_dim(), $urandom_range(256, 1048576),
                $urandom_range(0, 255), $urandom_range(0, 255));
      repeat ($urandom_range(6, 12)) random_frame();
    end while (bytes_sent < RANDOM_BYTES);

    settle();
    fault = fault_t'($urandom_range(0, 3));
    send_fault(fault);
    settle();

    $display("covered %0d byte transfers, %0d good frames, %0d register settings",
             bytes_sent, frames_sent, settings_used);
    $display("checked %0d events, run closed with a %s frame", events_checked,
             fault.name());
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
